[rtl/fl8_pkg.sv]
`default_nettype none
package fl8_pkg;

  localparam int unsigned MAX_FIELDS = 64;
  localparam int unsigned FC_W       = 7;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;

  localparam logic [FC_W-1:0]   FC_RESET    = 7'd52;
  localparam logic [FC_W-1:0]   FC_MAX      = FC_W'(MAX_FIELDS);
  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h41;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h71;
  localparam logic [BYTE_W-1:0] TYPE_TELEM  = 8'h54;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CHK_A,
    PH_CHK_B
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIELD,
    KIND_GOOD,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

[rtl/fl8_in_stage.sv]
`default_nettype none
module fl8_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [fl8_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       go,
  output logic                            in_stall,
  output logic                            vld,
  output logic [fl8_pkg::BYTE_W-1:0]      byte_q
);

  logic                       vld_r;
  logic                       vld_nxt;
  logic [fl8_pkg::BYTE_W-1:0] byte_r;
  logic                       take;

  assign in_stall = vld_r && !go;
  assign take     = in_valid && !in_stall;
  assign vld_nxt  = take ? 1'b1 : (go ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  assign vld    = vld_r;
  assign byte_q = byte_r;

endmodule
`default_nettype wire

[rtl/fl8_parser.sv]
`default_nettype none
module fl8_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       go,
  input  wire logic [fl8_pkg::BYTE_W-1:0] b,
  input  wire logic                       cfg_wr_en,
  input  wire logic [fl8_pkg::FC_W-1:0]   cfg_wr_data,
  output fl8_pkg::res_t                   res,
  output fl8_pkg::phase_t                 phase
);

  fl8_pkg::phase_t                 phase_r, phase_nxt;
  logic [fl8_pkg::FC_W-1:0]        fc_r;
  logic [fl8_pkg::BYTE_W-1:0]      sum_a_r, sum_a_nxt;
  logic [fl8_pkg::BYTE_W-1:0]      sum_b_r, sum_b_nxt;
  logic [1:0]                      bif_r, bif_nxt;
  logic [fl8_pkg::IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [23:0]                     part_r, part_nxt;
  logic [fl8_pkg::FC_W-1:0]        eff;
  logic [fl8_pkg::FC_W-1:0]        cnt_inc;
  logic [fl8_pkg::BYTE_W-1:0]      sum_a_add;
  logic [fl8_pkg::BYTE_W-1:0]      sum_b_add;
  logic                            field_done;
  logic                            frame_done;

  assign eff        = (fc_r > fl8_pkg::FC_MAX) ? fl8_pkg::FC_MAX : fc_r;
  assign cnt_inc    = {1'b0, cnt_r} + 7'd1;
  assign sum_a_add  = sum_a_r + b;
  assign sum_b_add  = sum_b_r + sum_a_add;
  assign field_done = (bif_r == 2'd3);
  assign frame_done = field_done && (cnt_inc >= eff);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      fl8_pkg::PH_HUNT: begin
        if (b == fl8_pkg::SYNC_FIRST) phase_nxt = fl8_pkg::PH_SYNC2;
      end
      fl8_pkg::PH_SYNC2: begin
        phase_nxt = (b == fl8_pkg::SYNC_SECOND) ? fl8_pkg::PH_TYPE : fl8_pkg::PH_HUNT;
      end
      fl8_pkg::PH_TYPE: begin
        if (b != fl8_pkg::TYPE_TELEM) begin
          phase_nxt = fl8_pkg::PH_HUNT;
        end else begin
          phase_nxt = (eff == '0) ? fl8_pkg::PH_CHK_A : fl8_pkg::PH_PAYLOAD;
        end
      end
      fl8_pkg::PH_PAYLOAD: begin
        if (frame_done) phase_nxt = fl8_pkg::PH_CHK_A;
      end
      fl8_pkg::PH_CHK_A: begin
        phase_nxt = (b != sum_a_r) ? fl8_pkg::PH_HUNT : fl8_pkg::PH_CHK_B;
      end
      fl8_pkg::PH_CHK_B: phase_nxt = fl8_pkg::PH_HUNT;
      default:           phase_nxt = fl8_pkg::PH_HUNT;
    endcase
  end

  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    bif_nxt   = bif_r;
    cnt_nxt   = cnt_r;
    part_nxt  = part_r;
    res       = '0;
    res.kind  = fl8_pkg::KIND_FIELD;
    unique case (phase_r)
      fl8_pkg::PH_SYNC2: begin
        if (b == fl8_pkg::SYNC_SECOND) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end
      end
      fl8_pkg::PH_TYPE: begin
        if (b == fl8_pkg::TYPE_TELEM) begin
          bif_nxt  = '0;
          cnt_nxt  = '0;
          part_nxt = '0;
        end
      end
      fl8_pkg::PH_PAYLOAD: begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        if (!field_done) begin
          unique case (bif_r)
            2'd0:    part_nxt = {part_r[23:8], b};
            2'd1:    part_nxt = {part_r[23:16], b, part_r[7:0]};
            default: part_nxt = {b, part_r[15:0]};
          endcase
          bif_nxt = bif_r + 2'd1;
        end else begin
          res.vld   = 1'b1;
          res.kind  = fl8_pkg::KIND_FIELD;
          res.idx   = cnt_r;
          res.value = {b, part_r};
          part_nxt  = '0;
          bif_nxt   = '0;
          cnt_nxt   = frame_done ? '0 : cnt_inc[fl8_pkg::IDX_W-1:0];
        end
      end
      fl8_pkg::PH_CHK_A: begin
        if (b != sum_a_r) begin
          res.vld  = 1'b1;
          res.kind = fl8_pkg::KIND_ERROR;
          res.last = 1'b1;
        end
      end
      fl8_pkg::PH_CHK_B: begin
        res.vld  = 1'b1;
        res.kind = (b == sum_b_r) ? fl8_pkg::KIND_GOOD : fl8_pkg::KIND_ERROR;
        res.last = 1'b1;
      end
      default: begin
      end
    endcase
    res.vld = res.vld && go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fl8_pkg::PH_HUNT;
      fc_r    <= fl8_pkg::FC_RESET;
      sum_a_r <= '0;
      sum_b_r <= '0;
      bif_r   <= '0;
      cnt_r   <= '0;
      part_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        fc_r <= cfg_wr_data;
      end
      if (go) begin
        phase_r <= phase_nxt;
        sum_a_r <= sum_a_nxt;
        sum_b_r <= sum_b_nxt;
        bif_r   <= bif_nxt;
        cnt_r   <= cnt_nxt;
        part_r  <= part_nxt;
      end
    end
  end

  assign phase = phase_r;

endmodule
`default_nettype wire

[rtl/fl8_out_stage.sv]
`default_nettype none
module fl8_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fl8_pkg::res_t res,
  input  wire logic          out_stall,
  output logic               ready,
  output fl8_pkg::res_t      res_q
);

  logic          vld_r, vld_nxt;
  fl8_pkg::res_t res_r;

  assign ready   = !vld_r || !out_stall;
  assign vld_nxt = res.vld ? 1'b1 : (out_stall ? vld_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      res_r <= res;
    end
  end

  always_comb begin
    res_q     = res_r;
    res_q.vld = vld_r;
  end

endmodule
`default_nettype wire

[rtl/sync_fletcher8_frame_deframer.sv]
`default_nettype none
// Byte-stream frame deframer. Each accepted byte passes an input register, the parse
// logic and a result register, so one byte is taken every clock cycle when the result
// side does not stall; its result is driven from the result register. Frames are
// 'A','q','T', then field_count four-byte little-endian fields (each emitted as a word
// with its index), then two Fletcher-8 check bytes; a status word with last set ends a
// frame. field_count above 64 acts as 64, zero means no fields. Write cfg only when idle.
module sync_fletcher8_frame_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_kind,
  output logic [5:0]                       out_field_index,
  output logic [31:0]                      out_field_value,
  output logic                             out_last,
  input  wire logic                        cfg_wr_en,
  input  wire logic [6:0]                  cfg_wr_data
);

  logic                       in_vld;
  logic [fl8_pkg::BYTE_W-1:0] in_byte_q;
  logic                       out_ready;
  logic                       go;
  fl8_pkg::res_t              res;
  fl8_pkg::res_t              res_q;
  fl8_pkg::phase_t            phase;

  assign go = in_vld && out_ready;

  fl8_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_rx_byte),
    .go       (go),
    .in_stall (in_stall),
    .vld      (in_vld),
    .byte_q   (in_byte_q)
  );

  fl8_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .b           (in_byte_q),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res),
    .phase       (phase)
  );

  fl8_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_stall (out_stall),
    .ready     (out_ready),
    .res_q     (res_q)
  );

  assign out_valid       = res_q.vld;
  assign out_kind        = res_q.kind;
  assign out_field_index = res_q.idx;
  assign out_field_value = res_q.value;
  assign out_last        = res_q.last;

  a_status_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind != fl8_pkg::KIND_FIELD &&
      out_field_index == '0 && out_field_value == '0)
    else $error("status word carries field data");

  a_field_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind == fl8_pkg::KIND_FIELD)
    else $error("non-last word is not a field");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld && out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && res.last |=> phase == fl8_pkg::PH_HUNT)
    else $error("parser not hunting after frame status");

endmodule
`default_nettype wire

[dv/fl8_deframe_checker.sv]
module fl8_deframe_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_kind,
  input  logic [5:0]                 out_field_index,
  input  logic [31:0]                out_field_value,
  input  logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [fl8_pkg::FC_W-1:0]   cfg_wr_data,
  output int                         fail_count,
  output int                         words_pending,
  output int                         words_checked,
  output int                         frames_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    fl8_pkg::kind_t kind;
    logic [5:0]     idx;
    logic [31:0]    value;
    logic           last;
  } deframed_t;

  deframed_t                expected_words[$];
  logic [fl8_pkg::FC_W-1:0] fields_per_frame;
  fl8_pkg::phase_t          phase;
  logic [7:0]               sum_a;
  logic [7:0]               sum_b;
  logic [1:0]               byte_pos;
  logic [5:0]               field_no;
  logic [23:0]              partial;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_checked = 0;
    frames_closed = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_CAP)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [fl8_pkg::FC_W-1:0] live_count();
    return (fields_per_frame > fl8_pkg::FC_MAX) ? fl8_pkg::FC_MAX : fields_per_frame;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    deframed_t                w;
    logic [fl8_pkg::FC_W-1:0] done;
    w = '0;
    case (phase)
      fl8_pkg::PH_HUNT: begin
        if (b == fl8_pkg::SYNC_FIRST) phase = fl8_pkg::PH_SYNC2;
      end
      fl8_pkg::PH_SYNC2: begin
        if (b == fl8_pkg::SYNC_SECOND) begin
          phase = fl8_pkg::PH_TYPE;
          sum_a = '0;
          sum_b = '0;
        end else begin
          phase = fl8_pkg::PH_HUNT;
        end
      end
      fl8_pkg::PH_TYPE: begin
        if (b != fl8_pkg::TYPE_TELEM) begin
          phase = fl8_pkg::PH_HUNT;
        end else begin
          byte_pos = '0;
          field_no = '0;
          partial  = '0;
          phase    = (live_count() == '0) ? fl8_pkg::PH_CHK_A : fl8_pkg::PH_PAYLOAD;
        end
      end
      fl8_pkg::PH_PAYLOAD: begin
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
        if (byte_pos != 2'd3) begin
          partial  = partial | (24'(b) << (8 * byte_pos));
          byte_pos = byte_pos + 2'd1;
        end else begin
          w.kind  = fl8_pkg::KIND_FIELD;
          w.idx   = field_no;
          w.value = {b, partial};
          expected_words.push_back(w);
          partial  = '0;
          byte_pos = '0;
          done     = {1'b0, field_no} + 7'd1;
          field_no = field_no + 6'd1;
          if (done >= live_count()) begin
            field_no = '0;
            phase    = fl8_pkg::PH_CHK_A;
          end
        end
      end
      fl8_pkg::PH_CHK_A: begin
        if (b != sum_a) begin
          phase  = fl8_pkg::PH_HUNT;
          w.kind = fl8_pkg::KIND_ERROR;
          w.last = 1'b1;
          expected_words.push_back(w);
        end else begin
          phase = fl8_pkg::PH_CHK_B;
        end
      end
      fl8_pkg::PH_CHK_B: begin
        phase  = fl8_pkg::PH_HUNT;
        w.kind = (b == sum_b) ? fl8_pkg::KIND_GOOD : fl8_pkg::KIND_ERROR;
        w.last = 1'b1;
        expected_words.push_back(w);
      end
      default: phase = fl8_pkg::PH_HUNT;
    endcase
  endtask

  always @(posedge clk) begin
    deframed_t want;
    if (!rst_n) begin
      phase            = fl8_pkg::PH_HUNT;
      sum_a            = '0;
      sum_b            = '0;
      byte_pos         = '0;
      field_no         = '0;
      partial          = '0;
      fields_per_frame = fl8_pkg::FC_RESET;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected", out_field_value, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", 32'(out_kind), 32'(want.kind));
          if (out_field_index !== want.idx)
            report_mismatch("field_index", 32'(out_field_index), 32'(want.idx));
          if (out_field_value !== want.value)
            report_mismatch("field_value", out_field_value, want.value);
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
          if (want.last) frames_closed++;
        end
      end
      if (cfg_wr_en) fields_per_frame = cfg_wr_data;
    end
    words_pending <= expected_words.size();
  end

endmodule

[dv/sync_fletcher8_frame_deframer_tb.sv]
module sync_fletcher8_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  localparam int FRAME_OK    = 0;
  localparam int FAULT_SUM_A = 1;
  localparam int FAULT_SUM_B = 2;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic [7:0]               in_rx_byte  = '0;
  logic                     out_stall   = 1'b0;
  logic                     cfg_wr_en   = 1'b0;
  logic [fl8_pkg::FC_W-1:0] cfg_wr_data = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic [1:0]               out_kind;
  logic [5:0]               out_field_index;
  logic [31:0]              out_field_value;
  logic                     out_last;

  int fail_count;
  int words_pending;
  int words_checked;
  int frames_closed;

  int                       cycle_count    = 0;
  int                       idle_pct       = 0;
  int                       stall_pct      = 0;
  int                       bytes_sent     = 0;
  bit                       long_hold_req  = 1'b0;
  bit                       long_hold_done = 1'b0;
  logic [fl8_pkg::FC_W-1:0] fc_now         = fl8_pkg::FC_RESET;
  logic [7:0]               tx_bytes[$];

  sync_fletcher8_frame_deframer dut (.*);

  fl8_deframe_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0) send_word(tx_bytes.pop_front());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_field_count(input logic [fl8_pkg::FC_W-1:0] n);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fc_now = n;
  endtask

  // fill below zero means random payload
  task automatic push_frame(input int nfields, input int fault, input int fill);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    a = '0;
    b = '0;
    tx_bytes.push_back(fl8_pkg::SYNC_FIRST);
    tx_bytes.push_back(fl8_pkg::SYNC_SECOND);
    tx_bytes.push_back(fl8_pkg::TYPE_TELEM);
    repeat (4 * nfields) begin
      d = (fill < 0) ? 8'($urandom) : 8'(fill);
      a = a + d;
      b = b + a;
      tx_bytes.push_back(d);
    end
    if (fault == FAULT_SUM_A) a = a ^ 8'($urandom_range(255, 1));
    if (fault == FAULT_SUM_B) b = b ^ 8'($urandom_range(255, 1));
    tx_bytes.push_back(a);
    tx_bytes.push_back(b);
  endtask

  task automatic gen_traffic(input int n);
    int         eff;
    int         pick;
    int         fault;
    logic [7:0] d;
    eff = int'((fc_now > fl8_pkg::FC_MAX) ? fl8_pkg::FC_MAX : fc_now);
    while (tx_bytes.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        fault = $urandom_range(99);
        fault = (fault < 70) ? FRAME_OK : (fault < 85) ? FAULT_SUM_A : FAULT_SUM_B;
        push_frame(eff, fault, -1);
      end else if (pick < 78) begin
        d = 8'($urandom);
        if (d == fl8_pkg::SYNC_SECOND) d = ~d;
        tx_bytes.push_back(fl8_pkg::SYNC_FIRST);
        tx_bytes.push_back(d);
      end else if (pick < 84) begin
        d = 8'($urandom);
        if (d == fl8_pkg::TYPE_TELEM) d = ~d;
        tx_bytes.push_back(fl8_pkg::SYNC_FIRST);
        tx_bytes.push_back(fl8_pkg::SYNC_SECOND);
        tx_bytes.push_back(d);
      end else if (pick < 90) begin
        tx_bytes.push_back(fl8_pkg::SYNC_FIRST);
        tx_bytes.push_back(fl8_pkg::SYNC_SECOND);
        tx_bytes.push_back(fl8_pkg::TYPE_TELEM);
        repeat ($urandom_range(4 * eff + 1)) tx_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(8, 1))
          tx_bytes.push_back(($urandom_range(3) == 0) ? fl8_pkg::SYNC_FIRST : 8'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [fl8_pkg::FC_W-1:0] fc, input int idle,
                           input int stall, input int n);
    write_field_count(fc);
    idle_pct  = idle;
    stall_pct = stall;
    gen_traffic(n);
    send_queued();
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // broken sync, wrong type, all-ones field, bad first trailer byte
    write_field_count(7'd1);
    tx_bytes = '{fl8_pkg::SYNC_FIRST, fl8_pkg::SYNC_FIRST, fl8_pkg::SYNC_FIRST,
                 fl8_pkg::SYNC_SECOND, 8'h53};
    push_frame(1, FRAME_OK, 8'hFF);
    push_frame(1, FAULT_SUM_A, 8'h00);
    send_queued();
    drain();
    // no payload, bad second trailer byte
    write_field_count(7'd0);
    push_frame(0, FAULT_SUM_B, 0);
    send_queued();
    drain();

    long_hold_req = 1'b1;
    run_phase(7'd3,   0,  0,  220);
    run_phase(7'd1,   80, 0,  220);
    run_phase(7'd64,  0,  80, 150);
    run_phase(7'd5,   17, 17, 220);
    run_phase(7'd127, 0,  0,  150);
    run_phase(7'd0,   80, 0,  100);
    run_phase(7'd2,   0,  80, 100);

    $display("Sent %0d bytes over field counts 0 to 127 with mixed sender and receiver gaps;",
             bytes_sent);
    $display("compared %0d result words, %0d of them frame status words.",
             words_checked, frames_closed);
    if (fail_count == 0 && words_pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
